>>> rtl/gpsd_pkg.sv
// Shared types and constants of the controller port and sprite DMA block.
package gpsd_pkg;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [4:0] OFF_DMA     = 5'h14;
    localparam logic [4:0] OFF_PAD_ONE = 5'h16;
    localparam logic [4:0] OFF_PAD_TWO = 5'h17;

    localparam logic [4:0]  PAD_LANES   = 5'h1F;
    localparam logic [15:0] SPRITE_PORT = 16'h2004;

    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_DUMMY = 2'd1;
    localparam logic [1:0] BUS_READ  = 2'd2;
    localparam logic [1:0] BUS_WRITE = 2'd3;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [3:0] {
        PH_FIRST = 4'b0001,
        PH_EXTRA = 4'b0010,
        PH_READ  = 4'b0100,
        PH_WRITE = 4'b1000
    } dma_phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] reg_offset;
        logic [7:0] wdata;
        logic [7:0] pad_one_buttons;
        logic [7:0] pad_two_buttons;
        logic       cycle_odd;
        logic [7:0] dma_rdata;
    } req_t;

    typedef struct packed {
        logic       rdata;
        logic [4:0] drive_mask;
    } pad_res_t;

    typedef struct packed {
        logic [1:0]  bus_op;
        logic [15:0] bus_addr;
        logic [7:0]  bus_wdata;
        logic        dma_busy;
    } dma_res_t;

endpackage

>>> rtl/gpsd_pads.sv
// Controller strobe, button latch and serial shift registers.
module gpsd_pads #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  gpsd_pkg::req_t    req,
    output gpsd_pkg::pad_res_t res
);
    import gpsd_pkg::*;

    logic                   strobe_reg;
    logic [NUM_BUTTONS-1:0] shift_reg [2];

    logic       is_pad;
    logic       sel;
    logic       do_read;
    logic       do_strobe;
    logic [7:0] live_sel;

    assign is_pad    = (req.reg_offset == OFF_PAD_ONE) || (req.reg_offset == OFF_PAD_TWO);
    assign sel       = req.reg_offset[0];
    assign do_read   = (req.req_type == REQ_READ) && is_pad;
    assign do_strobe = (req.req_type == REQ_WRITE) && (req.reg_offset == OFF_PAD_ONE);
    assign live_sel  = sel ? req.pad_two_buttons : req.pad_one_buttons;

    always_comb
    begin
        res.rdata      = 1'b0;
        res.drive_mask = 5'd0;
        if (do_read)
        begin
            res.drive_mask = PAD_LANES;
            res.rdata      = strobe_reg ? live_sel[0] : shift_reg[sel][0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg   <= 1'b0;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
        end
        else if (fire)
        begin
            if (do_read && !strobe_reg)
            begin
                shift_reg[sel] <= shift_reg[sel] >> 1;
            end
            if (do_strobe)
            begin
                // falling edge of the strobe latches both controllers
                if (strobe_reg && !req.wdata[0])
                begin
                    shift_reg[0] <= req.pad_one_buttons[NUM_BUTTONS-1:0];
                    shift_reg[1] <= req.pad_two_buttons[NUM_BUTTONS-1:0];
                end
                strobe_reg <= req.wdata[0];
            end
        end
    end

endmodule

>>> rtl/gpsd_dma.sv
// Sprite DMA sequencer: dummy cycles, then read/write pairs, one bus cycle per tick.
module gpsd_dma #(
    parameter int DMA_LENGTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  gpsd_pkg::req_t     req,
    output gpsd_pkg::dma_res_t res
);
    import gpsd_pkg::*;

    localparam int CW = $clog2(DMA_LENGTH + 1);
    localparam logic [CW-1:0] LAST = CW'(DMA_LENGTH - 1);

    logic          active_reg, active_next;
    logic [7:0]    page_reg, page_next;
    logic [CW-1:0] count_reg, count_next;
    dma_phase_t    phase_reg, phase_next;

    always_comb
    begin
        active_next   = active_reg;
        page_next     = page_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        res.bus_op    = BUS_NONE;
        res.bus_addr  = 16'd0;
        res.bus_wdata = 8'd0;
        if (req.req_type == REQ_TICK)
        begin
            if (active_reg)
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        res.bus_op = BUS_DUMMY;
                        phase_next = req.cycle_odd ? PH_EXTRA : PH_READ;
                    end
                    PH_EXTRA:
                    begin
                        res.bus_op = BUS_DUMMY;
                        phase_next = PH_READ;
                    end
                    PH_READ:
                    begin
                        res.bus_op   = BUS_READ;
                        res.bus_addr = {page_reg, 8'(count_reg)};
                        phase_next   = PH_WRITE;
                    end
                    PH_WRITE:
                    begin
                        res.bus_op    = BUS_WRITE;
                        res.bus_addr  = SPRITE_PORT;
                        res.bus_wdata = req.dma_rdata;
                        count_next    = count_reg + 1'b1;
                        if (count_reg == LAST)
                        begin
                            active_next = 1'b0;
                            phase_next  = PH_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_READ;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FIRST;
                    end
                endcase
            end
        end
        else if ((req.req_type == REQ_WRITE) && (req.reg_offset == OFF_DMA))
        begin
            // a start while running restarts with the new page
            active_next = 1'b1;
            page_next   = req.wdata;
            count_next  = '0;
            phase_next  = PH_FIRST;
        end
        res.dma_busy = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            page_reg   <= 8'd0;
            count_reg  <= '0;
            phase_reg  <= PH_FIRST;
        end
        else if (fire)
        begin
            active_reg <= active_next;
            page_reg   <= page_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

>>> rtl/gamepad_port_and_sprite_dma.sv
// Top level: controller ports and sprite DMA behind an item stream.
//
// Each input item is one bus request: a clock tick, a register read or a
// register write (s_tuser), with its offset, write byte, live controller
// buttons, cycle parity and the DMA read byte (s_tdata). Each item yields
// exactly one result item: the controller serial bit and lane mask, the DMA
// bus cycle of the tick (m_tuser), its address and write byte, and whether
// the DMA is still running (m_tdata).
//
// An item waits in the input register, where the pad and DMA logic
// evaluate it against the block state; the state updates as the item
// moves into the output register, which drives m_tvalid. Throughput is
// one item per cycle while the receiver takes results, with the state of
// the DMA sequencer and the shift registers fed back for the next item.
//
// Reset clears the strobe, both shift registers and the DMA state and
// empties both registers. When the receiver stalls, the result holds in the
// output register, one more item waits in the input register, and s_tready
// drops only once both are full.
module gamepad_port_and_sprite_dma #(
    parameter int DMA_LENGTH  = 256,
    parameter int NUM_BUTTONS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // reg_offset, wdata, pad_one_buttons, pad_two_buttons, cycle_odd, dma_rdata
    input  logic [gpsd_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rdata, drive_mask, bus_addr, bus_wdata, dma_busy
    output logic [gpsd_pkg::OUT_DATA_W-1:0]    m_tdata,
    // bus_op
    output logic [1:0]                         m_tuser
);
    import gpsd_pkg::*;

    logic                  in_valid_reg;
    req_t                  in_req_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]            out_user_reg;

    logic     advance;
    req_t     req_in;
    pad_res_t pad_res;
    dma_res_t dma_res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign req_in.req_type        = s_tuser;
    assign req_in.reg_offset      = s_tdata[4:0];
    assign req_in.wdata           = s_tdata[12:5];
    assign req_in.pad_one_buttons = s_tdata[20:13];
    assign req_in.pad_two_buttons = s_tdata[28:21];
    assign req_in.cycle_odd       = s_tdata[29];
    assign req_in.dma_rdata       = s_tdata[37:30];

    gpsd_pads #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_pads (
        .clk  (clk),
        .rst_n(rst_n),
        .fire (advance),
        .req  (in_req_reg),
        .res  (pad_res)
    );

    gpsd_dma #(
        .DMA_LENGTH(DMA_LENGTH)
    ) u_dma (
        .clk  (clk),
        .rst_n(rst_n),
        .fire (advance),
        .req  (in_req_reg),
        .res  (dma_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {1'b0, dma_res.dma_busy, dma_res.bus_wdata, dma_res.bus_addr,
                             pad_res.drive_mask, pad_res.rdata};
            out_user_reg <= dma_res.bus_op;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> rtl/gpsd_checker.sv
// Port-level checks of the controller port and sprite DMA block, with bind.
module gpsd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gpsd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser
);
    import gpsd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // with the output register empty the input side is always open
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with no result pending");

    // controller lanes are driven only on non-DMA items, and then fully
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[5:1] != 5'd0) |-> (m_tuser == BUS_NONE) &&
        (m_tdata[5:1] == PAD_LANES))
        else $error("bad drive mask");

    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == BUS_WRITE) |-> (m_tdata[21:6] == SPRITE_PORT))
        else $error("DMA write off the sprite port");

    // a dummy or read cycle is always followed by more DMA work
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == BUS_DUMMY) || (m_tuser == BUS_READ)) |-> m_tdata[30])
        else $error("DMA ended before its write");

endmodule

bind gamepad_port_and_sprite_dma gpsd_checker u_gpsd_checker (.*);
